// ----- hw/rtl/shp_pkg.sv -----
`timescale 1ns / 1ps

package shp_pkg;

    // Pixel, position, gain and configuration widths
    localparam int PIX_W    = 8;
    localparam int POS_W    = 10;
    localparam int GAIN_W   = 8;
    localparam int CFG_W    = 11;
    localparam int CFG_IDX_W = 2;
    // Wide enough for the 11-bit size registers and for sizes up to 4096
    localparam int SIZE_W   = 13;
    // Sum of eight neighbours: 8 * 255
    localparam int NSUM_W   = 11;
    // 8 * (gain + 8) * centre and gain * neighbour sum
    localparam int PROD_A_W = 20;
    localparam int PROD_B_W = 19;

    // Defaults for the top-level size parameters
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Smallest frame edge the filter works on
    localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(3);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_EIGHTHS = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0]  IMAGE_WIDTH_RST  = 11'd6;
    localparam logic [CFG_W-1:0]  IMAGE_HEIGHT_RST = 11'd6;
    localparam logic [GAIN_W-1:0] GAIN_RST         = 8'd32;

    // Window result handed from the window stage to the arithmetic
    typedef struct packed {
        logic [PIX_W-1:0]  centre;
        logic [NSUM_W-1:0] nsum;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } t_calc_req;

endpackage

// ----- hw/rtl/sharpen_3x3_clamp_filter.sv -----
`timescale 1ns / 1ps
// A result passes the window stage, products and output registers in turn.
// One pixel per cycle unless stalled; the line buffer is read and written once per beat.
// Only interior pixels produce a result beat; border pixels are absorbed.
// Reset clears position counters, pipeline valids and config registers (6, 6, 32).
// Line buffer contents are not cleared; no clearing pass, ready right after reset.
module sharpen_3x3_clamp_filter
    import shp_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [PIX_W-1:0]     i_pixel,
    input  logic                 i_frame_start,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [PIX_W-1:0]     o_filtered_pixel,
    output logic [POS_W-1:0]     o_out_row,
    output logic [POS_W-1:0]     o_out_col,
    output logic                 o_frame_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [SIZE_W-1:0] W_MAX = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] H_MAX = SIZE_W'(MAX_HEIGHT);

    // Configuration registers
    logic [CFG_W-1:0]  r_img_w;
    logic [CFG_W-1:0]  r_img_h;
    logic [GAIN_W-1:0] r_gain;

    // Position of the next pixel
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;

    // Window stage
    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_px;
    logic [COL_W-1:0]  r_s1_addr;
    logic              r_s1_emit;
    logic [POS_W-1:0]  r_s1_row;
    logic [POS_W-1:0]  r_s1_col;
    logic              r_s1_last;
    logic [PIX_W-1:0]  r_win [3][3];

    logic [SIZE_W-1:0] size_w;
    logic [SIZE_W-1:0] size_h;
    logic [SIZE_W-1:0] cfg_w_ext;
    logic [SIZE_W-1:0] cfg_h_ext;
    logic [SIZE_W-1:0] col_in;
    logic [SIZE_W-1:0] row_in;
    logic [SIZE_W-1:0] col_nx;
    logic [SIZE_W-1:0] row_nx;
    logic              emit;
    logic              last;
    logic              accept;
    logic              s1_fire;
    logic              calc_ready;
    logic [2*PIX_W-1:0] rd_data;
    logic [PIX_W-1:0]  col_top;
    logic [PIX_W-1:0]  col_mid;
    logic [NSUM_W-1:0] nsum;
    t_calc_req         calc_req;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= IMAGE_WIDTH_RST;
            r_img_h <= IMAGE_HEIGHT_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_img_w <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_img_h <= i_cfg_data;
                CFG_GAIN_EIGHTHS: r_gain  <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Frame size clamped to the supported range
    assign cfg_w_ext = SIZE_W'(r_img_w);
    assign cfg_h_ext = SIZE_W'(r_img_h);

    always_comb begin
        if (cfg_w_ext < SIZE_MIN) begin
            size_w = SIZE_MIN;
        end else if (cfg_w_ext > W_MAX) begin
            size_w = W_MAX;
        end else begin
            size_w = cfg_w_ext;
        end
        if (cfg_h_ext < SIZE_MIN) begin
            size_h = SIZE_MIN;
        end else if (cfg_h_ext > H_MAX) begin
            size_h = H_MAX;
        end else begin
            size_h = cfg_h_ext;
        end
    end

    // Position of this beat and of the next one, with wrap on a size change
    always_comb begin
        col_in = i_frame_start ? '0 : SIZE_W'(r_col);
        row_in = i_frame_start ? '0 : SIZE_W'(r_row);
        if (col_in >= size_w) begin
            col_in = '0;
            row_in = row_in + SIZE_W'(1);
        end
        if (row_in >= size_h) begin
            row_in = '0;
        end
        col_nx = col_in + SIZE_W'(1);
        row_nx = row_in;
        if (col_nx >= size_w) begin
            col_nx = '0;
            row_nx = row_in + SIZE_W'(1);
            if (row_nx >= size_h) begin
                row_nx = '0;
            end
        end
    end

    assign emit = (row_in >= SIZE_W'(2)) && (col_in >= SIZE_W'(2));
    assign last = (row_in == size_h - SIZE_W'(1)) && (col_in == size_w - SIZE_W'(1));

    // Handshake: window stage drains when its beat is no result or the arithmetic can take it
    assign s1_fire = r_s1_valid && (!r_s1_emit || calc_ready);
    assign o_ready = !r_s1_valid || s1_fire;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= col_nx[COL_W-1:0];
                r_row <= row_nx[ROW_W-1:0];
            end
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
        end
        if (accept) begin
            r_s1_px   <= i_pixel;
            r_s1_addr <= col_in[COL_W-1:0];
            r_s1_emit <= emit;
            r_s1_row  <= POS_W'(row_in - SIZE_W'(1));
            r_s1_col  <= POS_W'(col_in - SIZE_W'(1));
            r_s1_last <= last;
        end
    end

    // Line buffers: entry holds {two rows above, one row above}
    shp_line_buf #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (col_in[COL_W-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_addr),
        .i_wr_data ({rd_data[PIX_W-1:0], r_s1_px})
    );

    assign col_top = rd_data[2*PIX_W-1:PIX_W];
    assign col_mid = rd_data[PIX_W-1:0];

    // Window shift: oldest column drops, new column enters on the right
    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= col_top;
            r_win[1][2] <= col_mid;
            r_win[2][2] <= r_s1_px;
        end
    end

    // Neighbour sum of the shifted window; centre is the middle of the old right column
    assign nsum = NSUM_W'(r_win[0][1]) + NSUM_W'(r_win[1][1]) + NSUM_W'(r_win[2][1])
                + NSUM_W'(r_win[0][2]) + NSUM_W'(r_win[2][2])
                + NSUM_W'(col_top) + NSUM_W'(col_mid) + NSUM_W'(r_s1_px);

    assign calc_req.centre = r_win[1][2];
    assign calc_req.nsum   = nsum;
    assign calc_req.row    = r_s1_row;
    assign calc_req.col    = r_s1_col;
    assign calc_req.last   = r_s1_last;

    shp_calc u_calc (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (r_s1_valid && r_s1_emit),
        .o_req_ready      (calc_ready),
        .i_req            (calc_req),
        .i_gain           (r_gain),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_filtered_pixel (o_filtered_pixel),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_frame_last     (o_frame_last)
    );

endmodule

// ----- hw/rtl/shp_line_buf.sv -----
`timescale 1ns / 1ps

module shp_line_buf
    import shp_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = 2 * PIX_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_raw;
    logic [ADDR_W-1:0] r_rd_addr;
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [DATA_W-1:0] r_fwd_data;

    // Synchronous memory, read before write on the same address
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_raw  <= r_mem[i_rd_addr];
            r_rd_addr <= i_rd_addr;
        end
    end

    // Last write kept for forwarding; it always equals the memory contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_fwd_valid <= 1'b1;
        end
        if (i_wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    // A write that landed on the edge of the read wins over the stale read
    assign o_rd_data = (r_fwd_valid && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_raw;

endmodule

// ----- hw/rtl/shp_calc.sv -----
`timescale 1ns / 1ps

module shp_calc
    import shp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_calc_req         i_req,
    input  logic [GAIN_W-1:0] i_gain,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [PIX_W-1:0]  o_filtered_pixel,
    output logic [POS_W-1:0]  o_out_row,
    output logic [POS_W-1:0]  o_out_col,
    output logic              o_frame_last
);

    localparam int V_W = PROD_A_W + 1;

    logic                r_p_valid;
    logic [PROD_A_W-1:0] r_pa;
    logic [PROD_B_W-1:0] r_pb;
    logic [POS_W-1:0]    r_p_row;
    logic [POS_W-1:0]    r_p_col;
    logic                r_p_last;

    logic                r_o_valid;
    logic [PIX_W-1:0]    r_o_pix;
    logic [POS_W-1:0]    r_o_row;
    logic [POS_W-1:0]    r_o_col;
    logic                r_o_last;

    logic                o_load;
    logic                p_load;
    logic [GAIN_W:0]     gain_p8;
    logic [GAIN_W+PIX_W:0] prod_c;
    logic [PROD_A_W-1:0] n_pa;
    logic [PROD_B_W-1:0] n_pb;
    logic signed [V_W-1:0] v;
    logic [V_W-8:0]      v_shr;
    logic [PIX_W-1:0]    n_o_pix;

    // Flow control: output register frees up when taken or empty
    assign o_load      = !r_o_valid || i_ready;
    assign p_load      = !r_p_valid || o_load;
    assign o_req_ready = p_load;

    // Products stage
    assign gain_p8 = {1'b0, i_gain} + (GAIN_W+1)'(8);
    assign prod_c  = gain_p8 * i_req.centre;
    assign n_pa    = {prod_c, 3'b000};
    assign n_pb    = i_gain * i_req.nsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_load) begin
            r_p_valid <= i_req_valid;
        end
        if (p_load && i_req_valid) begin
            r_pa     <= n_pa;
            r_pb     <= n_pb;
            r_p_row  <= i_req.row;
            r_p_col  <= i_req.col;
            r_p_last <= i_req.last;
        end
    end

    // Difference, floor by 64 and clamp to the pixel range
    assign v     = $signed({1'b0, r_pa}) - $signed({2'b00, r_pb});
    assign v_shr = v[V_W-2:6];

    always_comb begin
        if (v[V_W-1]) begin
            n_o_pix = '0;
        end else if (v_shr > (V_W-7)'(255)) begin
            n_o_pix = '1;
        end else begin
            n_o_pix = v_shr[PIX_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_load) begin
            r_o_valid <= r_p_valid;
        end
        if (o_load && r_p_valid) begin
            r_o_pix  <= n_o_pix;
            r_o_row  <= r_p_row;
            r_o_col  <= r_p_col;
            r_o_last <= r_p_last;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_filtered_pixel = r_o_pix;
    assign o_out_row        = r_o_row;
    assign o_out_col        = r_o_col;
    assign o_frame_last     = r_o_last;

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import shp_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;
    localparam int MAX_H = MAX_HEIGHT_DEF;
    // Index that decodes to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int     RAND_ITEMS  = 950;
    localparam int     WIDE_ITEMS  = 40;
    localparam int     TALL_ITEMS  = 300;
    localparam int     IDLE_PAD    = 6;
    localparam int     HOLD_AT     = 50;
    localparam int     HOLD_CYCLES = 400;
    localparam int     DRAIN_MAX   = 20000;
    localparam longint CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             last;
    } t_sharp_px;

    typedef enum logic {ROW_PIXEL, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {STYLE_UNIFORM, STYLE_BINARY, STYLE_SMOOTH} t_pix_style;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
        logic [PIX_W-1:0]     px;
        logic                 fs;
        bit                   typed;
        t_sharp_px            want;
    } t_stim_row;

    // DUT signals
    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_valid       = 1'b0;
    logic                 o_ready;
    logic [PIX_W-1:0]     i_pixel       = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_valid;
    logic                 i_ready       = 1'b0;
    logic [PIX_W-1:0]     o_filtered_pixel;
    logic [POS_W-1:0]     o_out_row;
    logic [POS_W-1:0]     o_out_col;
    logic                 o_frame_last;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;

    sharpen_3x3_clamp_filter uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel          (i_pixel),
        .i_frame_start    (i_frame_start),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_filtered_pixel (o_filtered_pixel),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col),
        .o_frame_last     (o_frame_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Watchdog
    longint cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    int err_count     = 0;
    int checked_count = 0;
    bit burst_mode    = 1'b0;

    t_sharp_px sharpened_q[$];
    t_stim_row dir_tab[$];

    task automatic flag_error(input string what);
        err_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Filter state mirrored from the block
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]  width_reg  = IMAGE_WIDTH_RST;
    logic [CFG_W-1:0]  height_reg = IMAGE_HEIGHT_RST;
    logic [GAIN_W-1:0] gain_reg   = GAIN_RST;
    logic [PIX_W-1:0]  line1_mem [MAX_W] = '{default: '0};
    logic [PIX_W-1:0]  line2_mem [MAX_W] = '{default: '0};
    logic [PIX_W-1:0]  win_q [3][3]      = '{default: '0};
    int                col_writes [MAX_W];
    int                col_pos = 0;
    int                row_pos = 0;

    function automatic int size_clamp(input logic [CFG_W-1:0] v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Both line buffer rows hold real pixels in every column below w
    function automatic bit cols_ready(input int w);
        for (int c = 0; c < w; c++)
            if (col_writes[c] < 2) return 1'b0;
        return 1'b1;
    endfunction

    // One pixel beat: shift the window, update line buffers, sharpen the centre
    function automatic void sharpen_step(input logic [PIX_W-1:0] px, input logic fs,
                                         output bit got, output t_sharp_px res);
        int w, h, r, c, nsum, centre, g, v, q;
        w = size_clamp(width_reg, MAX_W);
        h = size_clamp(height_reg, MAX_H);
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        r = row_pos;
        c = col_pos;

        for (int i = 0; i < 3; i++) begin
            win_q[i][0] = win_q[i][1];
            win_q[i][1] = win_q[i][2];
        end
        win_q[0][2]    = line2_mem[c];
        win_q[1][2]    = line1_mem[c];
        win_q[2][2]    = px;
        line2_mem[c]   = line1_mem[c];
        line1_mem[c]   = px;
        if (col_writes[c] < 2) col_writes[c]++;

        got = 1'b0;
        res = '0;
        if (r >= 2 && c >= 2) begin
            nsum = 0;
            for (int a = 0; a < 3; a++)
                for (int b = 0; b < 3; b++)
                    nsum += int'(win_q[a][b]);
            centre = int'(win_q[1][1]);
            nsum  -= centre;
            g      = int'(gain_reg);
            v      = 8 * (g + 8) * centre - g * nsum;
            q      = (v < 0) ? 0 : (v >>> 6);
            res.pix  = (q > 255) ? 8'hFF : PIX_W'(q);
            res.row  = POS_W'(r - 1);
            res.col  = POS_W'(c - 1);
            res.last = (r == h - 1 && c == w - 1);
            got = 1'b1;
        end

        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = r + 1;
            if (row_pos >= h) row_pos = 0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one pixel beat; called at a falling edge, returns at one
    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs,
                              input bit typed, input t_sharp_px want);
        bit        got;
        t_sharp_px calc;
        int        gap;
        i_valid       <= 1'b1;
        i_pixel       <= px;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sharpen_step(px, fs, got, calc);
        if (typed) sharpened_q.push_back(want);
        else if (got) sharpened_q.push_back(calc);
        @(negedge i_clk);
        gap = burst_mode ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Stop offering pixels and let the pipeline empty
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sharpened_q.size() != 0) @(negedge i_clk);
        repeat (IDLE_PAD) @(negedge i_clk);
    endtask

    // One register write beat; leaves valid high for back-to-back writes
    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_IMAGE_WIDTH:  width_reg  = data;
            CFG_IMAGE_HEIGHT: height_reg = data;
            CFG_GAIN_EIGHTHS: gain_reg   = data[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic write_regs(input logic [2:0] mask, input logic [CFG_W-1:0] w,
                              input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] g);
        if (mask == 3'b000) return;
        wait_idle();
        if (mask[0]) cfg_beat(CFG_IMAGE_WIDTH, w);
        if (mask[1]) cfg_beat(CFG_IMAGE_HEIGHT, h);
        if (mask[2]) cfg_beat(CFG_GAIN_EIGHTHS, g);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return CFG_W'($urandom_range(0, 2));
        if (r == 1) return CFG_W'($urandom_range(11, 40));
        return CFG_W'($urandom_range(3, 10));
    endfunction

    // Gain with junk in the unused upper data bits
    function automatic logic [CFG_W-1:0] pick_gain();
        int r;
        logic [GAIN_W-1:0] g;
        r = $urandom_range(0, 7);
        if (r == 0) g = 8'h00;
        else if (r == 1) g = 8'hFF;
        else g = GAIN_W'($urandom);
        return {3'($urandom), g};
    endfunction

    // Stream n pixels; flen > 0 means frames aligned to the phase start
    task automatic run_phase(input int n, input int flen, input int noise,
                             input t_pix_style style);
        int               base, v;
        logic             fs;
        logic [PIX_W-1:0] px;
        base = $urandom_range(0, 255);
        for (int k = 0; k < n; k++) begin
            fs = 1'b0;
            if (flen > 0 && k % flen == 0) fs = (k == 0) ? 1'b1 : 1'($urandom);
            if (noise > 0 && $urandom_range(1, noise) == 1) fs = 1'b1;
            case (style)
                STYLE_BINARY: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                STYLE_SMOOTH: begin
                    v  = base - 8 + int'($urandom_range(0, 16));
                    px = (v < 0) ? 8'h00 : (v > 255) ? 8'hFF : PIX_W'(v);
                end
                default: px = PIX_W'($urandom);
            endcase
            send_pixel(px, fs, 1'b0, '0);
        end
    endtask

    // Directed table builders
    function automatic void tab_px(input logic [PIX_W-1:0] px, input logic fs);
        t_stim_row t;
        t = '{kind: ROW_PIXEL, idx: '0, data: '0, px: px, fs: fs, typed: 1'b0, want: '0};
        dir_tab.push_back(t);
    endfunction

    function automatic void tab_chk(input logic [PIX_W-1:0] px, input logic fs,
                                    input logic [PIX_W-1:0] pix, input int r, input int c,
                                    input logic last);
        t_stim_row t;
        t = '{kind: ROW_PIXEL, idx: '0, data: '0, px: px, fs: fs, typed: 1'b1,
              want: '{pix: pix, row: POS_W'(r), col: POS_W'(c), last: last}};
        dir_tab.push_back(t);
    endfunction

    function automatic void tab_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
        t_stim_row t;
        t = '{kind: ROW_CFG, idx: idx, data: data, px: '0, fs: 1'b0, typed: 1'b0, want: '0};
        dir_tab.push_back(t);
    endfunction

    // ------------------------------------------------------------------
    // Result side: compare each accepted beat with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : out_check
        t_sharp_px want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sharpened_q.size() == 0) begin
                flag_error($sformatf("result beat with nothing pending (r%0d c%0d)",
                                     o_out_row, o_out_col));
            end else begin
                want = sharpened_q.pop_front();
                checked_count++;
                if (o_filtered_pixel !== want.pix)
                    flag_error($sformatf("pixel %0d, want %0d at r%0d c%0d",
                                         o_filtered_pixel, want.pix, want.row, want.col));
                if (o_out_row !== want.row)
                    flag_error($sformatf("row %0d, want %0d", o_out_row, want.row));
                if (o_out_col !== want.col)
                    flag_error($sformatf("col %0d, want %0d", o_out_col, want.col));
                if (o_frame_last !== want.last)
                    flag_error($sformatf("frame_last %0b, want %0b at r%0d c%0d",
                                         o_frame_last, want.last, want.row, want.col));
            end
        end
    end

    // Result ready: random stalls, calm stretches, one long hold-off
    initial begin : sink_ready
        int stall_left;
        int hold_left;
        int calm_left;
        bit calm;
        bit held;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        calm       = 1'b0;
        held       = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && checked_count >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm) stall_left = idle_len();
            end
            if (calm_left == 0) begin
                calm      = ($urandom_range(0, 3) == 0);
                calm_left = 300;
            end else begin
                calm_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row        row_q;
        logic [2:0]       mask;
        logic [CFG_W-1:0] w_cfg;
        logic [CFG_W-1:0] h_cfg;
        int               kind, n, flen, sent, waited;
        t_pix_style       style;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset sizes 6x6, gain 32: dark centre in a bright ring floors to zero
        tab_px(8'd255, 1'b0); tab_px(8'd255, 1'b0); tab_px(8'd255, 1'b0);
        tab_px(8'd0, 1'b0);   tab_px(8'd0, 1'b0);   tab_px(8'd0, 1'b0);
        tab_px(8'd255, 1'b0); tab_px(8'd0, 1'b0);   tab_px(8'd255, 1'b0);
        tab_px(8'd0, 1'b0);   tab_px(8'd0, 1'b0);   tab_px(8'd0, 1'b0);
        tab_px(8'd255, 1'b0); tab_px(8'd255, 1'b0);
        tab_chk(8'd255, 1'b0, 8'd0, 1, 1, 1'b0);
        // Sizes below 3 clamp to 3x3, spare index ignored, gain upper bits dropped
        tab_cfg(CFG_IMAGE_WIDTH, 11'd0);
        tab_cfg(CFG_IMAGE_HEIGHT, 11'd2);
        tab_cfg(CFG_SPARE, 11'h7FF);
        tab_cfg(CFG_GAIN_EIGHTHS, 11'h7FF);
        // Bright centre at full gain saturates; single interior pixel is frame end
        tab_px(8'd0, 1'b1);   tab_px(8'd0, 1'b0);   tab_px(8'd0, 1'b0);
        tab_px(8'd0, 1'b0);   tab_px(8'd255, 1'b0); tab_px(8'd0, 1'b0);
        tab_px(8'd0, 1'b0);   tab_px(8'd0, 1'b0);
        tab_chk(8'd0, 1'b0, 8'd255, 1, 1, 1'b1);

        foreach (dir_tab[k]) begin
            row_q = dir_tab[k];
            if (row_q.kind == ROW_CFG) begin
                if (k == 0 || dir_tab[k-1].kind != ROW_CFG) wait_idle();
                cfg_beat(row_q.idx, row_q.data);
                if (k + 1 == dir_tab.size() || dir_tab[k+1].kind != ROW_CFG)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_pixel(row_q.px, row_q.fs, row_q.typed, row_q.want);
            end
        end

        // Width above the maximum clamps: a stretch of row 0, no results yet
        write_regs(3'b111, 11'h7FF, 11'd3, pick_gain());
        run_phase(WIDE_ITEMS, 3 * MAX_W, 0, STYLE_UNIFORM);
        // Tallest frame, first rows of it
        write_regs(3'b111, 11'd3, 11'd1024, pick_gain());
        run_phase(TALL_ITEMS, 3 * MAX_H, 0, STYLE_UNIFORM);

        // Random phases
        sent = 0;
        while (sent < RAND_ITEMS) begin
            kind       = $urandom_range(0, 9);
            burst_mode = ($urandom_range(0, 3) == 0);
            style      = t_pix_style'($urandom_range(0, 2));
            if (kind <= 6) begin
                // whole frames, sometimes with a partial one trailing
                mask = {1'($urandom), 2'b11};
                write_regs(mask, pick_size(), pick_size(), pick_gain());
                flen = size_clamp(width_reg, MAX_W) * size_clamp(height_reg, MAX_H);
                n = flen * ((flen > 200) ? 1 : $urandom_range(1, 3));
                if ($urandom_range(0, 3) == 0) n += $urandom_range(1, flen - 1);
                if (n > RAND_ITEMS - sent) n = RAND_ITEMS - sent;
                run_phase(n, flen, 0, style);
            end else if (kind <= 8) begin
                // size change in mid-frame; widen only over filled columns
                w_cfg = pick_size();
                if (!cols_ready(size_clamp(w_cfg, MAX_W))) w_cfg = width_reg;
                h_cfg = pick_size();
                mask  = 3'($urandom);
                write_regs(mask, w_cfg, h_cfg, pick_gain());
                n = $urandom_range(5, 60);
                run_phase(n, 0, 0, style);
            end else begin
                // stray frame starts
                n = $urandom_range(10, 60);
                run_phase(n, 0, 8, style);
            end
            sent += n;
        end

        // Drain
        i_valid <= 1'b0;
        waited = 0;
        while (sharpened_q.size() != 0 && waited < DRAIN_MAX) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (IDLE_PAD + 4) @(negedge i_clk);
        if (sharpened_q.size() != 0)
            flag_error($sformatf("%0d results never came out", sharpened_q.size()));
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sharpen_3x3_clamp_filter.f -----
hw/rtl/shp_pkg.sv
hw/rtl/shp_line_buf.sv
hw/rtl/shp_calc.sv
hw/rtl/sharpen_3x3_clamp_filter.sv
verif/tb_top.sv
